@@ hw/rtl/pdv_pkg.sv @@
// Shared types and constants for the perspective divide / viewport unit.
// No dependencies; every other rtl file refers to this package by scoped name.
package pdv_pkg;

    localparam int DATA_W  = 32;
    localparam int TAG_W   = 16;
    localparam int DEPTH_W = 17;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_X      = 3'd0,
        CFG_SCALE_Y      = 3'd1,
        CFG_ORIGIN_X     = 3'd2,
        CFG_ORIGIN_Y     = 3'd3,
        CFG_DEPTH_GAIN   = 3'd4,
        CFG_DEPTH_OFFSET = 3'd5
    } cfg_idx_t;

    // One incoming vertex transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] clip_x;
        logic signed [DATA_W-1:0] clip_y;
        logic signed [DATA_W-1:0] clip_z;
        logic signed [DATA_W-1:0] clip_w;
        logic        [TAG_W-1:0]  vertex_tag;
    } in_t;

    // One outgoing screen-space transaction
    typedef struct packed {
        logic signed [DATA_W-1:0]  screen_x;
        logic signed [DATA_W-1:0]  screen_y;
        logic        [DEPTH_W-1:0] screen_depth;
        logic signed [DATA_W-1:0]  recip_w;
        logic        [TAG_W-1:0]   tag_out;
    } out_t;

    // Clamped coordinates and tag carried beside the divider
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic        [TAG_W-1:0]  tag;
    } side_t;

endpackage

@@ hw/rtl/pdv_div_step.sv @@
// One restoring-division stage: produces one quotient bit per register stage.
// Depends on pdv_pkg (side_t).
module pdv_div_step #(
    parameter int QW   = 33,
    parameter bit LEAD = 1'b0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    input  logic [31:0]                   rem_in,
    input  logic [QW-1:0]                 q_in,
    input  logic [31:0]                   dvs_in,
    input  logic                          neg_in,
    input  logic                          zero_in,
    input  pdv_pkg::side_t                side_in,
    output logic [31:0]                   rem_out,
    output logic [QW-1:0]                 q_out,
    output logic [31:0]                   dvs_out,
    output logic                          neg_out,
    output logic                          zero_out,
    output pdv_pkg::side_t                side_out
);

    logic                 valid_reg;
    logic [31:0]          rem_reg, rem_next;
    logic [QW-1:0]        q_reg, q_next;
    logic [31:0]          dvs_reg;
    logic                 neg_reg, zero_reg;
    pdv_pkg::side_t       side_reg;
    logic [32:0]          trial, diff;
    logic                 ge;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        trial    = {rem_in, LEAD};
        diff     = trial - {1'b0, dvs_in};
        ge       = (trial >= {1'b0, dvs_in});
        rem_next = ge ? diff[31:0] : trial[31:0];
        q_next   = {q_in[QW-2:0], ge};
    end

    assign up_ready = !valid_reg || dn_ready;

    // Advance valid when the stage is free or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    // Load payload on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            dvs_reg  <= dvs_in;
            neg_reg  <= neg_in;
            zero_reg <= zero_in;
            side_reg <= side_in;
        end
    end

    assign dn_valid = valid_reg;
    assign rem_out  = rem_reg;
    assign q_out    = q_reg;
    assign dvs_out  = dvs_reg;
    assign neg_out  = neg_reg;
    assign zero_out = zero_reg;
    assign side_out = side_reg;

endmodule

@@ hw/rtl/pdv_recip.sv @@
// Pipelined reciprocal 2^(2*FRAC_BITS)/w: one divider stage per quotient bit,
// then a sign and saturation stage. Depends on pdv_pkg and pdv_div_step.
module pdv_recip #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    input  logic [31:0]           dvs_in,
    input  logic                  neg_in,
    input  logic                  zero_in,
    input  pdv_pkg::side_t        side_in,
    output logic signed [31:0]    rw_out,
    output pdv_pkg::side_t        side_out
);

    localparam int QW  = 2 * FRAC_BITS + 1;
    localparam int QEW = (QW > 33) ? QW : 33;

    logic [31:0]     rem_a  [QW+1];
    logic [QW-1:0]   q_a    [QW+1];
    logic [31:0]     dvs_a  [QW+1];
    logic            neg_a  [QW+1];
    logic            zero_a [QW+1];
    pdv_pkg::side_t  side_a [QW+1];
    logic            vld_a  [QW+1];
    logic            rdy_a  [QW+1];

    logic                  valid_reg;
    logic signed [31:0]    rw_reg, rw_next;
    pdv_pkg::side_t        side_reg;
    logic [QEW-1:0]        qe;

    assign rem_a[0]  = '0;
    assign q_a[0]    = '0;
    assign dvs_a[0]  = dvs_in;
    assign neg_a[0]  = neg_in;
    assign zero_a[0] = zero_in;
    assign side_a[0] = side_in;
    assign vld_a[0]  = up_valid;
    assign up_ready  = rdy_a[0];

    // Divider chain, most significant quotient bit first
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        pdv_div_step #(
            .QW   (QW),
            .LEAD ((k == 0) ? 1'b1 : 1'b0)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (vld_a[k]),
            .up_ready (rdy_a[k]),
            .dn_valid (vld_a[k+1]),
            .dn_ready (rdy_a[k+1]),
            .rem_in   (rem_a[k]),
            .q_in     (q_a[k]),
            .dvs_in   (dvs_a[k]),
            .neg_in   (neg_a[k]),
            .zero_in  (zero_a[k]),
            .side_in  (side_a[k]),
            .rem_out  (rem_a[k+1]),
            .q_out    (q_a[k+1]),
            .dvs_out  (dvs_a[k+1]),
            .neg_out  (neg_a[k+1]),
            .zero_out (zero_a[k+1]),
            .side_out (side_a[k+1])
        );
    end

    // Apply sign and saturate the quotient magnitude
    always_comb
    begin
        qe = QEW'(q_a[QW]);
        if (zero_a[QW])
            rw_next = '0;
        else if (!neg_a[QW])
            rw_next = (qe > QEW'(33'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(qe[31:0]);
        else
            rw_next = (qe > QEW'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                   : $signed(32'(-qe[31:0]));
    end

    assign rdy_a[QW] = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (rdy_a[QW])
            valid_reg <= vld_a[QW];
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a[QW] && vld_a[QW])
        begin
            rw_reg   <= rw_next;
            side_reg <= side_a[QW];
        end
    end

    assign dn_valid = valid_reg;
    assign rw_out   = rw_reg;
    assign side_out = side_reg;

endmodule

@@ hw/rtl/pdv_map.sv @@
// Viewport mapping: three register stages (coord product, gain product,
// offset and saturate). Depends on pdv_pkg.
module pdv_map #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    output logic               dn_valid,
    input  logic               dn_ready,
    input  logic signed [31:0] rw_in,
    input  pdv_pkg::side_t     side_in,
    input  logic signed [31:0] gain_x,
    input  logic signed [31:0] gain_y,
    input  logic signed [31:0] gain_z,
    input  logic signed [31:0] org_x,
    input  logic signed [31:0] org_y,
    input  logic signed [31:0] org_z,
    output pdv_pkg::out_t      dn_data
);

    localparam int TW   = FRAC_BITS + 2;
    localparam int PW   = TW + 32;
    localparam int SH_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SH_L = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
    localparam logic signed [33:0] S32_MIN = -34'sd2147483648;
    localparam logic signed [33:0] ONE     = 34'sd1 <<< FRAC_BITS;

    logic               v1_reg, v2_reg, v3_reg;
    logic               r1, r2, r3;
    logic signed [31:0] coord [3];
    logic signed [31:0] gain  [3];
    logic signed [31:0] org   [3];

    logic signed [63:0]   p_reg  [3];
    logic signed [TW-1:0] t      [3];
    logic signed [PW-1:0] m_reg  [3];
    logic signed [33:0]   u      [3];
    logic signed [31:0]   sat    [3];
    logic [FRAC_BITS:0]   dcl;
    logic [16:0]          depth;

    logic signed [31:0] rw1_reg, rw2_reg;
    logic [15:0]        tag1_reg, tag2_reg;
    pdv_pkg::out_t      out_reg, out_next;

    assign coord[0] = side_in.x;
    assign coord[1] = side_in.y;
    assign coord[2] = side_in.z;
    assign gain[0]  = gain_x;
    assign gain[1]  = gain_y;
    assign gain[2]  = gain_z;
    assign org[0]   = org_x;
    assign org[1]   = org_y;
    assign org[2]   = org_z;

    // Ready chain, output side first
    assign r3       = !v3_reg || dn_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign up_ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= up_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
        end
    end

    // Floor-scale the products and finish each lane
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t[i] = TW'(p_reg[i] >>> FRAC_BITS);
            u[i] = 34'(m_reg[i] >>> FRAC_BITS) + 34'(org[i]);
            if (u[i] > S32_MAX)
                sat[i] = 32'sh7FFF_FFFF;
            else if (u[i] < S32_MIN)
                sat[i] = 32'sh8000_0000;
            else
                sat[i] = u[i][31:0];
        end
        if (u[2] < 34'sd0)
            dcl = '0;
        else if (u[2] > ONE)
            dcl = ONE[FRAC_BITS:0];
        else
            dcl = u[2][FRAC_BITS:0];
        depth = 17'((34'(dcl) << SH_L) >> SH_R);

        out_next.screen_x     = sat[0];
        out_next.screen_y     = sat[1];
        out_next.screen_depth = depth;
        out_next.recip_w      = rw2_reg;
        out_next.tag_out      = tag2_reg;
    end

    // Stage 1: reciprocal times coordinate
    always_ff @(posedge clk)
    begin
        if (r1 && up_valid)
        begin
            for (int i = 0; i < 3; i++)
                p_reg[i] <= rw_in * coord[i];
            rw1_reg  <= rw_in;
            tag1_reg <= side_in.tag;
        end
    end

    // Stage 2: scaled coordinate times gain
    always_ff @(posedge clk)
    begin
        if (r2 && v1_reg)
        begin
            for (int i = 0; i < 3; i++)
                m_reg[i] <= t[i] * gain[i];
            rw2_reg  <= rw1_reg;
            tag2_reg <= tag1_reg;
        end
    end

    // Stage 3: offset, saturate, hold for output
    always_ff @(posedge clk)
    begin
        if (r3 && v2_reg)
            out_reg <= out_next;
    end

    assign dn_valid = v3_reg;
    assign dn_data  = out_reg;

endmodule

@@ hw/rtl/perspective_divide_viewport_unit.sv @@
// Perspective divide and viewport transform, top level. Depends on pdv_pkg,
// pdv_recip (with pdv_div_step) and pdv_map.
// Stages: input register, one divider stage per quotient bit, sign and
// saturation stage, viewport stages. Throughput: one vertex per cycle while
// out_stall is low; every stage drains independently, so bubbles are filled
// under stall. Reset zeroes all valid bits and the six viewport registers.
module perspective_divide_viewport_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  pdv_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pdv_pkg::out_t                  out_data,
    input  logic                           cfg_we,
    input  logic [pdv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pdv_pkg::DATA_W-1:0]     cfg_data
);

    logic signed [31:0] scale_x_reg, scale_y_reg, origin_x_reg, origin_y_reg;
    logic signed [31:0] depth_gain_reg, depth_offset_reg;

    logic               v0_reg, r0;
    pdv_pkg::side_t     side0_reg, side0_next;
    logic [31:0]        dvs0_reg, dvs0_next;
    logic               neg0_reg, zero0_reg;

    logic signed [32:0] w33, nw33;
    logic signed [32:0] c1 [3];
    logic signed [32:0] c2 [3];
    logic signed [31:0] cin [3];

    logic               rc_valid, rc_ready, rc_up_ready;
    logic signed [31:0] rw;
    pdv_pkg::side_t     rc_side;

    // Write the viewport registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg      <= '0;
            scale_y_reg      <= '0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            depth_gain_reg   <= '0;
            depth_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (pdv_pkg::cfg_idx_t'(cfg_index))
                pdv_pkg::CFG_SCALE_X:      scale_x_reg      <= cfg_data;
                pdv_pkg::CFG_SCALE_Y:      scale_y_reg      <= cfg_data;
                pdv_pkg::CFG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                pdv_pkg::CFG_ORIGIN_Y:     origin_y_reg     <= cfg_data;
                pdv_pkg::CFG_DEPTH_GAIN:   depth_gain_reg   <= cfg_data;
                pdv_pkg::CFG_DEPTH_OFFSET: depth_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp to -w then w, take |w|
    always_comb
    begin
        cin[0] = in_data.clip_x;
        cin[1] = in_data.clip_y;
        cin[2] = in_data.clip_z;
        w33    = 33'(in_data.clip_w);
        nw33   = -w33;
        for (int i = 0; i < 3; i++)
        begin
            c1[i] = (33'(cin[i]) < nw33) ? nw33 : 33'(cin[i]);
            c2[i] = (c1[i] > w33) ? w33 : c1[i];
        end
        side0_next.x   = c2[0][31:0];
        side0_next.y   = c2[1][31:0];
        side0_next.z   = c2[2][31:0];
        side0_next.tag = in_data.vertex_tag;
        dvs0_next      = in_data.clip_w[31] ? 32'(-in_data.clip_w) : in_data.clip_w;
    end

    assign r0       = !v0_reg || rc_up_ready;
    assign in_stall = !r0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (r0)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (r0 && in_valid)
        begin
            side0_reg <= side0_next;
            dvs0_reg  <= dvs0_next;
            neg0_reg  <= in_data.clip_w[31];
            zero0_reg <= (in_data.clip_w == '0);
        end
    end

    pdv_recip #(
        .FRAC_BITS (FRAC_BITS)
    ) u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v0_reg),
        .up_ready (rc_up_ready),
        .dn_valid (rc_valid),
        .dn_ready (rc_ready),
        .dvs_in   (dvs0_reg),
        .neg_in   (neg0_reg),
        .zero_in  (zero0_reg),
        .side_in  (side0_reg),
        .rw_out   (rw),
        .side_out (rc_side)
    );

    pdv_map #(
        .FRAC_BITS (FRAC_BITS)
    ) u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (rc_valid),
        .up_ready (rc_ready),
        .dn_valid (out_valid),
        .dn_ready (!out_stall),
        .rw_in    (rw),
        .side_in  (rc_side),
        .gain_x   (scale_x_reg),
        .gain_y   (scale_y_reg),
        .gain_z   (depth_gain_reg),
        .org_x    (origin_x_reg),
        .org_y    (origin_y_reg),
        .org_z    (depth_offset_reg),
        .dn_data  (out_data)
    );

endmodule

@@ hw/rtl/pdv_checker.sv @@
// Port-level checks for the perspective divide / viewport unit, bound to the
// top level. Depends on pdv_pkg and perspective_divide_viewport_unit.
module pdv_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input pdv_pkg::out_t out_data
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output transaction changed");

    // Back-pressure reaches the input only when the whole pipe is full
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output side can drain");

    // Depth never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.screen_depth <= 17'd65536)
        else $error("depth out of range");

    // An idle output side never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

endmodule

bind perspective_divide_viewport_unit pdv_checker u_pdv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

@@ test/tb_perspective_divide_viewport_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for perspective_divide_viewport_unit.
// Depends on pdv_pkg; predicts every vertex and compares results in order.
module tb_perspective_divide_viewport_unit;

    localparam int FRAC = 16;
    localparam int LATENCY = 2 * FRAC + 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1290;
    localparam logic [pdv_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    pdv_pkg::in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    pdv_pkg::out_t out_data;
    logic cfg_we = 1'b0;
    logic [pdv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pdv_pkg::DATA_W-1:0] cfg_data = '0;

    // viewport copy used by the predictor
    longint vp_scale_x, vp_scale_y, vp_origin_x, vp_origin_y, vp_dgain, vp_doff;

    pdv_pkg::out_t pending_q[$];
    int fail_count = 0;
    int cycle_count = 0;
    bit quiet_rx = 1'b0;   // no random idling
    bit hold_rx = 1'b0;    // long receiver hold-off request

    perspective_divide_viewport_unit #(.FRAC_BITS(FRAC)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // floor division by 2^FRAC
    function automatic longint floor_frac(longint v);
        return v >>> FRAC;
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_w(longint c, longint w);
        longint r;
        r = c;
        if (r < -w) r = -w;
        if (r > w) r = w;
        return r;
    endfunction

    function automatic longint viewport_map(longint rw, longint c, longint g, longint o);
        longint t;
        t = floor_frac(rw * c);
        return floor_frac(t * g) + o;
    endfunction

    // compute the screen-space vertex for one clip-space vertex
    function automatic pdv_pkg::out_t project_vertex(pdv_pkg::in_t v);
        pdv_pkg::out_t r;
        longint w, x, y, z, rw, d;
        w = longint'(v.clip_w);
        x = clamp_w(longint'(v.clip_x), w);
        y = clamp_w(longint'(v.clip_y), w);
        z = clamp_w(longint'(v.clip_z), w);
        rw = 0;
        if (w != 0) rw = sat_word((64'sd1 << (2 * FRAC)) / w);
        r.screen_x = pdv_pkg::DATA_W'(sat_word(viewport_map(rw, x, vp_scale_x, vp_origin_x)));
        r.screen_y = pdv_pkg::DATA_W'(sat_word(viewport_map(rw, y, vp_scale_y, vp_origin_y)));
        d = viewport_map(rw, z, vp_dgain, vp_doff);
        if (d < 0) d = 0;
        if (d > (64'sd1 << FRAC)) d = 64'sd1 << FRAC;
        r.screen_depth = pdv_pkg::DEPTH_W'(d);
        r.recip_w = pdv_pkg::DATA_W'(rw);
        r.tag_out = v.vertex_tag;
        return r;
    endfunction

    // write one register, then wait with cfg_we low before returning
    task automatic write_reg(logic [pdv_pkg::CFG_IDX_W-1:0] idx,
                             logic [pdv_pkg::DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            pdv_pkg::CFG_SCALE_X:      vp_scale_x = longint'(signed'(val));
            pdv_pkg::CFG_SCALE_Y:      vp_scale_y = longint'(signed'(val));
            pdv_pkg::CFG_ORIGIN_X:     vp_origin_x = longint'(signed'(val));
            pdv_pkg::CFG_ORIGIN_Y:     vp_origin_y = longint'(signed'(val));
            pdv_pkg::CFG_DEPTH_GAIN:   vp_dgain = longint'(signed'(val));
            pdv_pkg::CFG_DEPTH_OFFSET: vp_doff = longint'(signed'(val));
            default: ;
        endcase
        @(posedge clk);
    endtask

    // drop valid, wait until every result is back, then let the pipeline settle
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // offer one transaction, with optional random idle before it
    task automatic send_vertex(pdv_pkg::in_t v, bit idle_ok, bit has_gold,
                               pdv_pkg::out_t gold);
        pdv_pkg::out_t exp_v;
        if (idle_ok)
        begin
            while ($urandom_range(99) < 6)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        exp_v = project_vertex(v);
        if (has_gold && exp_v !== gold)
        begin
            $error("directed row tag %0d: table %h predictor %h", v.vertex_tag, gold, exp_v);
            fail_count++;
        end
        pending_q.push_back(exp_v);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return 32'h7FFF_FFFF - $urandom_range(3);
            3: return $urandom_range(8);
            default: return 32'($signed($urandom_range(262144)) - 131072);
        endcase
    endfunction

    function automatic pdv_pkg::in_t rand_vertex();
        pdv_pkg::in_t v;
        logic [31:0] w;
        case ($urandom_range(9))
            0: w = 32'd0;
            1: w = 32'($signed($urandom_range(40)) - 20);
            2: w = $urandom;
            3: w = 32'h8000_0000;
            default: w = 32'($signed($urandom_range(1 << 20)) - (1 << 19));
        endcase
        v.clip_w = w;
        v.clip_x = rand_coord();
        v.clip_y = rand_coord();
        v.clip_z = rand_coord();
        v.vertex_tag = 16'($urandom);
        return v;
    endfunction

    // directed table: x, y, z, w, tag; gold row checked only where obvious
    typedef struct {
        pdv_pkg::in_t v;
        bit has_gold;
        pdv_pkg::out_t gold;
    } row_t;

    row_t dir_rows[$];

    task automatic add_row(logic [31:0] x, y, z, w, logic [15:0] tg, bit g,
                           pdv_pkg::out_t gold);
        row_t r;
        r.v = '{x, y, z, w, tg};
        r.has_gold = g;
        r.gold = gold;
        dir_rows.push_back(r);
    endtask

    // receiver stall generation
    always @(posedge clk)
    begin
        if (hold_rx) out_stall <= 1'b1;
        else if (!quiet_rx) out_stall <= ($urandom_range(99) < 6);
        else out_stall <= 1'b0;
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        pdv_pkg::out_t exp_v;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $error("unexpected result tag %0d", out_data.tag_out);
                fail_count++;
            end
            else
            begin
                exp_v = pending_q.pop_front();
                if (out_data.screen_x !== exp_v.screen_x)
                begin
                    $error("screen_x exp %h got %h", exp_v.screen_x, out_data.screen_x);
                    fail_count++;
                end
                if (out_data.screen_y !== exp_v.screen_y)
                begin
                    $error("screen_y exp %h got %h", exp_v.screen_y, out_data.screen_y);
                    fail_count++;
                end
                if (out_data.screen_depth !== exp_v.screen_depth)
                begin
                    $error("screen_depth exp %h got %h", exp_v.screen_depth,
                           out_data.screen_depth);
                    fail_count++;
                end
                if (out_data.recip_w !== exp_v.recip_w)
                begin
                    $error("recip_w exp %h got %h", exp_v.recip_w, out_data.recip_w);
                    fail_count++;
                end
                if (out_data.tag_out !== exp_v.tag_out)
                begin
                    $error("tag_out exp %h got %h", exp_v.tag_out, out_data.tag_out);
                    fail_count++;
                end
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    task automatic long_hold(int cycles);
        hold_rx = 1'b1;
        repeat (cycles) @(posedge clk);
        hold_rx = 1'b0;
    endtask

    initial
    begin
        pdv_pkg::out_t zero_res;
        pdv_pkg::out_t sat_res;
        int phase;
        vp_scale_x = 0; vp_scale_y = 0; vp_origin_x = 0;
        vp_origin_y = 0; vp_dgain = 0; vp_doff = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset all registers are zero: only recip_w and tag survive
        zero_res = '0;
        zero_res.tag_out = 16'h0001;
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 16'h0001, 1'b1, zero_res);
        sat_res = '0;
        sat_res.recip_w = 32'h7FFF_FFFF;
        sat_res.tag_out = 16'hFFFF;
        add_row(32'h0, 32'h0, 32'h0, 32'h1, 16'hFFFF, 1'b1, sat_res);
        sat_res.recip_w = 32'h8000_0000;
        sat_res.tag_out = 16'h0000;
        add_row(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 16'h0000, 1'b1, sat_res);
        foreach (dir_rows[i])
            send_vertex(dir_rows[i].v, 1'b0, dir_rows[i].has_gold, dir_rows[i].gold);
        drain_pipe();

        // typical viewport, then directed rows checked by the predictor
        write_reg(pdv_pkg::CFG_SCALE_X, 32'h0140_0000);
        write_reg(pdv_pkg::CFG_SCALE_Y, 32'hFF10_0000);
        write_reg(pdv_pkg::CFG_ORIGIN_X, 32'h0140_0000);
        write_reg(pdv_pkg::CFG_ORIGIN_Y, 32'h00F0_0000);
        write_reg(pdv_pkg::CFG_DEPTH_GAIN, 32'h0000_8000);
        write_reg(pdv_pkg::CFG_DEPTH_OFFSET, 32'h0000_8000);
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        dir_rows.delete();
        add_row(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0002_0000, 16'h10, 0, '0);
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 16'h11, 0, '0);
        add_row(32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 32'hFFFE_0000, 16'h12, 0, '0);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h13, 0, '0);
        add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h14, 0, '0);
        add_row(32'h5, 32'hFFFF_FFFB, 32'h3, 32'h0, 16'h15, 0, '0);
        add_row(32'h1, 32'hFFFF_FFFF, 32'h1, 32'h1, 16'h16, 0, '0);
        add_row(32'h2, 32'h1, 32'hFFFF_FFFF, 32'h2, 16'h17, 0, '0);
        add_row(32'hFFFF_FFFF, 32'h1, 32'h0, 32'hFFFF_FFFF, 16'h18, 0, '0);
        add_row(32'h0000_C000, 32'hFFFF_4000, 32'hFFFF_0000, 32'h0001_0000, 16'h19, 0, '0);
        foreach (dir_rows[i]) send_vertex(dir_rows[i].v, 1'b1, 1'b0, '0);
        drain_pipe();

        // random phases through several register settings, extremes included
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: ;
                1:
                begin
                    write_reg(pdv_pkg::CFG_SCALE_X, 32'h7FFF_FFFF);
                    write_reg(pdv_pkg::CFG_SCALE_Y, 32'h8000_0000);
                    write_reg(pdv_pkg::CFG_ORIGIN_X, 32'h7FFF_FFFF);
                    write_reg(pdv_pkg::CFG_ORIGIN_Y, 32'h8000_0000);
                    write_reg(pdv_pkg::CFG_DEPTH_GAIN, 32'h7FFF_FFFF);
                    write_reg(pdv_pkg::CFG_DEPTH_OFFSET, 32'h8000_0000);
                end
                2:
                begin
                    write_reg(pdv_pkg::CFG_SCALE_X, 32'h8000_0000);
                    write_reg(pdv_pkg::CFG_SCALE_Y, 32'h7FFF_FFFF);
                    write_reg(pdv_pkg::CFG_ORIGIN_X, 32'h8000_0000);
                    write_reg(pdv_pkg::CFG_ORIGIN_Y, 32'h7FFF_FFFF);
                    write_reg(pdv_pkg::CFG_DEPTH_GAIN, 32'h8000_0000);
                    write_reg(pdv_pkg::CFG_DEPTH_OFFSET, 32'h7FFF_FFFF);
                end
                default:
                begin
                    write_reg(pdv_pkg::CFG_SCALE_X, $urandom);
                    write_reg(pdv_pkg::CFG_SCALE_Y, $urandom);
                    write_reg(pdv_pkg::CFG_ORIGIN_X, $urandom);
                    write_reg(pdv_pkg::CFG_ORIGIN_Y, $urandom);
                    write_reg(pdv_pkg::CFG_DEPTH_GAIN,
                              32'($signed($urandom_range(1 << 18)) - (1 << 17)));
                    write_reg(pdv_pkg::CFG_DEPTH_OFFSET, $urandom_range(1 << 17));
                    write_reg(3'($urandom_range(7)), $urandom);
                end
            endcase
            quiet_rx = (phase == 4);
            if (phase == 2)
            begin
                // fill the pipe behind a long receiver hold-off
                fork
                    long_hold(300);
                    repeat (150) send_vertex(rand_vertex(), 1'b0, 1'b0, '0);
                join
            end
            repeat (RANDOM_ITEMS / 6) send_vertex(rand_vertex(), phase != 4, 1'b0, '0);
            // sender pauses until all results are back
            drain_pipe();
        end
        quiet_rx = 1'b0;

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
